@@ rtl/pixel_cubic_inverse_calibration_core_assert.svh @@
// Assertion macros shared by the calibration core RTL.
`ifndef PIXEL_CUBIC_INVERSE_CALIBRATION_CORE_ASSERT_SVH
`define PIXEL_CUBIC_INVERSE_CALIBRATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pcic_pkg.sv @@
// Shared types, constants and saturating helpers of the calibration core.
package pcic_pkg;

    typedef logic signed [47:0] t_q48;

    localparam t_q48 MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam t_q48 MIN48 = 48'sh8000_0000_0000;

    // Quotient bits produced by the division cells, and divider latency.
    localparam int DIV_BITS = 47;
    localparam int DIV_LAT  = DIV_BITS + 2;
    localparam int MUL_LAT  = 2;
    localparam int SCALE_LAT = 2 * MUL_LAT + DIV_LAT;

    // Pixel kinds.
    localparam logic [2:0] KIND_CAL  = 3'd0;
    localparam logic [2:0] KIND_NULL = 3'd1;
    localparam logic [2:0] KIND_LRS  = 3'd2;
    localparam logic [2:0] KIND_LIS  = 3'd3;
    localparam logic [2:0] KIND_HIS  = 3'd4;
    localparam logic [2:0] KIND_HRS  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MASK_EN   = 3'd0;
    localparam logic [2:0] CFG_BLEM_EN   = 3'd1;
    localparam logic [2:0] CFG_INIT_GUESS = 3'd2;
    localparam logic [2:0] CFG_SUN_DIST  = 3'd3;
    localparam logic [2:0] CFG_ABS_COEF  = 3'd4;
    localparam logic [2:0] CFG_EXPOSURE  = 3'd5;

    // One pixel travelling down the Newton chain.
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        t_q48       c0d;
        t_q48       c1;
        t_q48       c2;
        t_q48       c3;
        t_q48       x;
    } t_rec;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
    } t_tag;

    // State handed from one division cell to the next.
    typedef struct packed {
        logic [47:0]         r;
        logic [DIV_BITS-1:0] rest;
        logic [DIV_BITS-1:0] q;
        logic [47:0]         md;
        logic                neg;
        logic                fix;
        t_q48                fixv;
    } t_div_st;

    function automatic logic [47:0] mag48(input t_q48 v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic t_q48 sat_mag(input logic [50:0] m, input logic neg);
        if (m >= 51'h8000_0000_0000) begin
            return neg ? MIN48 : MAX48;
        end
        return neg ? -t_q48'(m[47:0]) : t_q48'(m[47:0]);
    endfunction

    function automatic t_q48 sat50(input logic signed [49:0] v);
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            return t_q48'(v[47:0]);
        end
        return v[49] ? MIN48 : MAX48;
    endfunction

    function automatic t_q48 sat_add(input t_q48 a, input t_q48 b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) begin
            return s[48] ? MIN48 : MAX48;
        end
        return t_q48'(s[47:0]);
    endfunction

    function automatic t_q48 sat_sub(input t_q48 a, input t_q48 b);
        logic signed [48:0] s;
        s = {a[47], a} - {b[47], b};
        if (s[48] != s[47]) begin
            return s[48] ? MIN48 : MAX48;
        end
        return t_q48'(s[47:0]);
    endfunction

    function automatic t_q48 times2(input t_q48 t);
        logic signed [49:0] e;
        e = {{2{t[47]}}, t};
        return sat50(e <<< 1);
    endfunction

    function automatic t_q48 times3(input t_q48 t);
        logic signed [49:0] e;
        e = {{2{t[47]}}, t};
        return sat50(e + (e <<< 1));
    endfunction

endpackage

@@ rtl/pcic_qmul.sv @@
// Two-stage Q24.24 multiplier: 24-bit partial products, then round and saturate.
module pcic_qmul import pcic_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q48 i_a,
    input  t_q48 i_b,
    output t_q48 o_p
);

    logic [47:0] w_ma, w_mb;
    logic [47:0] r_hh, r_hl, r_lh, r_ll;
    logic        r_neg;
    logic [47:0] w_rnd;
    logic [50:0] w_sum;
    t_q48        n_p, r_p;

    assign w_ma = mag48(i_a);
    assign w_mb = mag48(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh  <= w_ma[47:24] * w_mb[47:24];
            r_hl  <= w_ma[47:24] * w_mb[23:0];
            r_lh  <= w_ma[23:0] * w_mb[47:24];
            r_ll  <= w_ma[23:0] * w_mb[23:0];
            r_neg <= i_a[47] ^ i_b[47];
        end
    end

    // Round the low product half away from zero, on the magnitude.
    assign w_rnd = (r_ll + 48'h80_0000) >> 24;
    assign w_sum = {4'b0, r_hh[22:0], 24'b0} + {3'b0, r_hl} + {3'b0, r_lh} + 51'(w_rnd);

    always_comb begin
        if (|r_hh[47:23]) begin
            n_p = r_neg ? MIN48 : MAX48;
        end else begin
            n_p = sat_mag(w_sum, r_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/pcic_div_cell.sv @@
// One restoring-division cell: one quotient bit per cycle while i_en is high.
module pcic_div_cell import pcic_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_div_st i_st,
    output t_div_st o_st
);

    logic [48:0] w_rr;
    logic        w_ge;
    t_div_st     n_st, r_st;

    assign w_rr = {i_st.r, i_st.rest[DIV_BITS-1]};
    assign w_ge = w_rr >= {1'b0, i_st.md};

    always_comb begin
        n_st      = i_st;
        n_st.r    = w_ge ? 48'(w_rr - {1'b0, i_st.md}) : w_rr[47:0];
        n_st.q    = {i_st.q[DIV_BITS-2:0], w_ge};
        n_st.rest = {i_st.rest[DIV_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

@@ rtl/pcic_qdiv.sv @@
// Pipelined Q24.24 divider, truncating toward zero, built from a row of cells.
module pcic_qdiv import pcic_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q48 i_n,
    input  t_q48 i_d,
    output t_q48 o_q
);

    logic [47:0] w_mn, w_md;
    logic        w_dz, w_ovf;
    t_div_st     n_setup, r_setup;
    t_div_st     w_st [DIV_BITS+1];
    t_q48        w_qv, n_q, r_q;

    assign w_mn  = mag48(i_n);
    assign w_md  = mag48(i_d);
    assign w_dz  = (w_md == 48'd0);
    // Quotient of 2^47 or more saturates.
    assign w_ovf = {23'b0, w_mn} >= {w_md, 23'b0};

    always_comb begin
        n_setup.r    = 48'(w_mn[47:23]);
        n_setup.rest = {w_mn[22:0], 24'b0};
        n_setup.q    = '0;
        n_setup.md   = w_md;
        n_setup.neg  = i_n[47] ^ i_d[47];
        n_setup.fix  = w_dz | w_ovf;
        if (w_dz) begin
            n_setup.fixv = (i_n == '0) ? '0 : (i_n[47] ? MIN48 : MAX48);
        end else begin
            n_setup.fixv = n_setup.neg ? MIN48 : MAX48;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_setup <= n_setup;
        end
    end

    assign w_st[0] = r_setup;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
        pcic_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_st  (w_st[k]),
            .o_st  (w_st[k+1])
        );
    end

    assign w_qv = t_q48'({1'b0, w_st[DIV_BITS].q});

    always_comb begin
        if (w_st[DIV_BITS].fix) begin
            n_q = w_st[DIV_BITS].fixv;
        end else begin
            n_q = w_st[DIV_BITS].neg ? -w_qv : w_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/pcic_newton.sv @@
// One Newton step cell of the cubic inversion, fully pipelined.
module pcic_newton import pcic_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_rec i_rec,
    output t_rec o_rec
);

    typedef struct packed {
        t_rec rec;
        t_q48 t2;
        t_q48 t3;
        t_q48 t5;
        t_q48 g;
        t_q48 f;
    } t_nst;

    typedef struct packed {
        t_rec rec;
        logic gnz;
    } t_nrec;

    t_rec  r_q1, r_q2, n_out, r_out;
    t_nst  n_s3, r_s3, r_s4, n_s5, r_s5, r_s6, n_s7, r_s7;
    t_nrec r_dly [DIV_LAT];
    t_q48  w_x2, w_c1x, w_c2x, w_x3, w_c3x2, w_c2x2, w_c3x3, w_q;

    pcic_qmul u_x2   (.i_clk, .i_en, .i_a(i_rec.x),  .i_b(i_rec.x), .o_p(w_x2));
    pcic_qmul u_c1x  (.i_clk, .i_en, .i_a(i_rec.c1), .i_b(i_rec.x), .o_p(w_c1x));
    pcic_qmul u_c2x  (.i_clk, .i_en, .i_a(i_rec.c2), .i_b(i_rec.x), .o_p(w_c2x));
    pcic_qmul u_x3   (.i_clk, .i_en, .i_a(w_x2),     .i_b(r_q2.x),  .o_p(w_x3));
    pcic_qmul u_c3x2 (.i_clk, .i_en, .i_a(r_q2.c3),  .i_b(w_x2),    .o_p(w_c3x2));
    pcic_qmul u_c2x2 (.i_clk, .i_en, .i_a(r_q2.c2),  .i_b(w_x2),    .o_p(w_c2x2));
    pcic_qmul u_c3x3 (.i_clk, .i_en, .i_a(r_s4.rec.c3), .i_b(w_x3), .o_p(w_c3x3));

    always_comb begin
        n_s3     = r_s4;
        n_s3.rec = r_q2;
        n_s3.t3  = w_c1x;
        n_s3.t5  = w_c2x;
    end

    // Slope: 3*c3*x^2 + 2*c2*x + c1.
    always_comb begin
        n_s5    = r_s4;
        n_s5.t2 = w_c2x2;
        n_s5.g  = sat_add(sat_add(times3(w_c3x2), times2(r_s4.t5)), r_s4.rec.c1);
    end

    // Residual: c3*x^3 + c2*x^2 + c1*x + (c0 - d).
    always_comb begin
        n_s7   = r_s6;
        n_s7.f = sat_add(sat_add(sat_add(w_c3x3, r_s6.t2), r_s6.t3), r_s6.rec.c0d);
    end

    pcic_qdiv u_div (.i_clk, .i_en, .i_n(r_s7.f), .i_d(r_s7.g), .o_q(w_q));

    // Skip the step when the slope is zero.
    always_comb begin
        n_out = r_dly[DIV_LAT-1].rec;
        if (r_dly[DIV_LAT-1].gnz) begin
            n_out.x = sat_sub(r_dly[DIV_LAT-1].rec.x, w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1.valid     <= 1'b0;
            r_q2.valid     <= 1'b0;
            r_s3.rec.valid <= 1'b0;
            r_s4.rec.valid <= 1'b0;
            r_s5.rec.valid <= 1'b0;
            r_s6.rec.valid <= 1'b0;
            r_s7.rec.valid <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dly[k].rec.valid <= 1'b0;
            end
            r_out.valid    <= 1'b0;
        end else if (i_en) begin
            r_q1 <= i_rec;
            r_q2 <= r_q1;
            r_s3 <= n_s3;
            r_s4 <= r_s3;
            r_s5 <= n_s5;
            r_s6 <= r_s5;
            r_s7 <= n_s7;
            r_dly[0] <= {r_s7.rec, (r_s7.g != '0)};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_rec = r_out;

endmodule

@@ rtl/pixel_cubic_inverse_calibration_core.sv @@
// Top level of the per-pixel cubic inverse calibration core.
// One pixel transaction is accepted per clock and one result transaction leaves per
// clock, in order, as long as the output is not stalled. A pixel passes through the
// classification and dark subtraction register, then through every Newton cell (its
// multiplier stages, a divider row of one cell per quotient bit, an update register),
// then through scaling (two multipliers and a divider) and the output register. The
// whole pipeline advances together whenever the skid register is empty; a result
// stalled at the output is parked in the skid register so one further pixel can
// still be taken, after which o_ready drops until the skid register has moved its
// result into the output register. Special pixel kinds pass straight through, failed
// checks give kind 1 and radiance is zero unless kind 0. Configuration writes take
// effect at once and must only be made while idle; the squared sun distance is
// recomputed from the registered sun distance after a write.
`include "pixel_cubic_inverse_calibration_core_assert.svh"

module pixel_cubic_inverse_calibration_core import pcic_pkg::*; #(
    parameter int NEWTON_STEPS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pixel_value,
    input  logic [2:0]         i_pixel_kind,
    input  logic signed [31:0] i_dark_value,
    input  logic               i_dark_special,
    input  logic               i_blemish_bad,
    input  logic signed [47:0] i_coef_constant,
    input  logic signed [47:0] i_coef_linear,
    input  logic signed [47:0] i_coef_square,
    input  logic signed [47:0] i_coef_cube,
    input  logic signed [31:0] i_valid_low,
    input  logic signed [31:0] i_valid_high,
    input  logic               i_coef_special,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_out_kind,
    output logic signed [47:0] o_radiance
);

    // Configuration registers.
    logic        r_mask_en, r_blem_en;
    t_q48        r_init_guess;
    logic [31:0] r_sun, r_abs, r_exp;
    logic [63:0] w_sq;
    t_q48        r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_en    <= 1'b0;
            r_blem_en    <= 1'b0;
            r_init_guess <= '0;
            r_sun        <= 32'd16777216;
            r_abs        <= 32'd1048576;
            r_exp        <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASK_EN:    r_mask_en    <= i_cfg_data[0];
                CFG_BLEM_EN:    r_blem_en    <= i_cfg_data[0];
                CFG_INIT_GUESS: r_init_guess <= t_q48'(i_cfg_data);
                CFG_SUN_DIST:   r_sun        <= i_cfg_data[31:0];
                CFG_ABS_COEF:   r_abs        <= i_cfg_data[31:0];
                CFG_EXPOSURE:   r_exp        <= i_cfg_data[31:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Squared sun distance, Q16.48 rounded half up to Q24.24.
    assign w_sq = r_sun * r_sun;

    always_ff @(posedge i_clk) begin
        r_s2 <= t_q48'({7'b0, 41'(w_sq[63:24]) + 41'(w_sq[23])});
    end

    // Pipeline advance: hold every stage before the output register while the skid register is occupied.
    logic r_skid_valid;
    logic w_en;

    assign w_en    = !r_skid_valid;
    assign o_ready = w_en;

    // Front stage: classify the pixel and subtract the dark current.
    logic signed [32:0] w_diff;
    t_q48               w_d;
    t_rec               n_front, r_front;

    assign w_diff = {i_pixel_value[31], i_pixel_value} - {i_dark_value[31], i_dark_value};
    assign w_d    = t_q48'({{7{w_diff[32]}}, w_diff, 8'b0});

    always_comb begin
        n_front.valid = i_valid;
        n_front.kind  = KIND_NULL;
        n_front.c0d   = sat_sub(i_coef_constant, w_d);
        n_front.c1    = i_coef_linear;
        n_front.c2    = i_coef_square;
        n_front.c3    = i_coef_cube;
        n_front.x     = r_init_guess;
        case (i_pixel_kind) inside
            KIND_CAL: begin
                if (i_dark_special || (r_blem_en && i_blemish_bad) || i_coef_special) begin
                    n_front.kind = KIND_NULL;
                end else if (r_mask_en && ((i_pixel_value < i_valid_low) ||
                                           (i_pixel_value > i_valid_high))) begin
                    n_front.kind = KIND_NULL;
                end else if (w_diff[32] || (w_diff == '0)) begin
                    n_front.kind = KIND_NULL;
                end else begin
                    n_front.kind = KIND_CAL;
                end
            end
            KIND_NULL, KIND_LRS, KIND_LIS, KIND_HIS, KIND_HRS: begin
                n_front.kind = i_pixel_kind;
            end
            default: begin
                n_front.kind = KIND_NULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_en) begin
            r_front <= n_front;
        end
    end

    // Row of Newton cells.
    t_rec w_rec [NEWTON_STEPS+1];

    assign w_rec[0] = r_front;

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
        pcic_newton u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_rec   (w_rec[k]),
            .o_rec   (w_rec[k+1])
        );
    end

    // Scaling: ((x * s2) * abs) / exposure, with abs and exposure moved to Q24.24.
    t_q48 w_abs24, w_exp24, w_y1, w_y2, w_y;
    t_tag r_tag [SCALE_LAT];
    t_tag w_last;
    t_q48 w_last_rad;

    assign w_abs24 = t_q48'({8'b0, r_abs, 8'b0});
    assign w_exp24 = t_q48'({8'b0, r_exp, 8'b0});

    pcic_qmul u_mul_sun (.i_clk, .i_en(w_en), .i_a(w_rec[NEWTON_STEPS].x), .i_b(r_s2),
                         .o_p(w_y1));
    pcic_qmul u_mul_abs (.i_clk, .i_en(w_en), .i_a(w_y1), .i_b(w_abs24), .o_p(w_y2));
    pcic_qdiv u_div_exp (.i_clk, .i_en(w_en), .i_n(w_y2), .i_d(w_exp24), .o_q(w_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SCALE_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_tag[0] <= {w_rec[NEWTON_STEPS].valid, w_rec[NEWTON_STEPS].kind};
            for (int k = 1; k < SCALE_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign w_last     = r_tag[SCALE_LAT-1];
    assign w_last_rad = (w_last.kind == KIND_CAL) ? w_y : '0;

    // Output register with a one-deep skid behind it.
    logic       r_out_valid;
    logic [2:0] r_out_kind, r_skid_kind;
    t_q48       r_out_rad, r_skid_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_out_kind   <= r_skid_kind;
                r_out_rad    <= r_skid_rad;
                r_skid_valid <= 1'b0;
            end
        end else if (w_last.valid) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= w_last.kind;
                r_out_rad   <= w_last_rad;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_kind  <= w_last.kind;
                r_skid_rad   <= w_last_rad;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_kind = r_out_kind;
    assign o_radiance = r_out_rad;

    `PCIC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds a transaction while the output register is empty")
    `PCIC_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n,
        (w_last.valid && !r_skid_valid && r_out_valid && !i_ready), r_skid_valid,
        "stalled result was not parked in the skid register")
    `PCIC_ASSERT_IMP(a_rad_zero, i_clk, i_rst_n, (o_valid && (o_out_kind != KIND_CAL)),
        (o_radiance == '0), "non-zero radiance on an uncalibrated result")
    `PCIC_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, o_valid, (o_out_kind <= KIND_HRS),
        "result kind out of range")

endmodule

@@ bench/pixel_cubic_inverse_calibration_core_checker.sv @@
// Checker for the calibration core: predicts every pixel result and compares it.
`timescale 1ns / 100ps

module pixel_cubic_inverse_calibration_core_checker import pcic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [31:0] i_pixel_value,
    input  logic [2:0]         i_pixel_kind,
    input  logic signed [31:0] i_dark_value,
    input  logic               i_dark_special,
    input  logic               i_blemish_bad,
    input  logic signed [47:0] i_coef_constant,
    input  logic signed [47:0] i_coef_linear,
    input  logic signed [47:0] i_coef_square,
    input  logic signed [47:0] i_coef_cube,
    input  logic signed [31:0] i_valid_low,
    input  logic signed [31:0] i_valid_high,
    input  logic               i_coef_special,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [2:0]         i_out_kind,
    input  logic signed [47:0] i_radiance,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int                   STEPS   = 9;
    localparam longint               SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint               SAT_MIN = -SAT_MAX - 1;
    localparam longint unsigned      TWO48   = 64'h1_0000_0000_0000;
    localparam longint unsigned      TWO23   = 64'h80_0000;
    localparam longint unsigned      LOW24   = 64'hFF_FFFF;

    typedef struct {
        logic [2:0]         kind;
        logic signed [47:0] radiance;
    } t_pixel_result;

    logic               mask_on;
    logic               blemish_on;
    logic signed [47:0] start_guess;
    logic [31:0]        sun_dist;
    logic [31:0]        abs_coef;
    logic [31:0]        exposure;

    t_pixel_result calibrated_due[$];

    function automatic longint clamp48(input longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint apply_sign(input longint unsigned mag, input logic neg);
        longint unsigned m;
        m = mag > TWO48 ? TWO48 : mag;
        return clamp48(neg ? -longint'(m) : longint'(m));
    endfunction

    // Q24.24 product, magnitude rounded half away from zero.
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma, mb, ah, al, bh, bl, hi, mag;
        ma = magnitude(a);
        mb = magnitude(b);
        ah = ma >> 24;
        al = ma & LOW24;
        bh = mb >> 24;
        bl = mb & LOW24;
        hi = ah * bh;
        if (hi >= TWO23) mag = TWO48;
        else mag = (hi << 24) + ah * bl + al * bh + ((al * bl + TWO23) >> 24);
        return apply_sign(mag, (a < 0) != (b < 0));
    endfunction

    // Q24.24 quotient, truncated toward zero.
    function automatic longint fx_div(input longint n, input longint d);
        longint unsigned mn, md, q, r;
        mn = magnitude(n);
        md = magnitude(d);
        if (md == 0) begin
            if (n == 0) return 0;
            return n < 0 ? SAT_MIN : SAT_MAX;
        end
        q = mn / md;
        r = mn % md;
        if (q >= TWO23) return apply_sign(TWO48, (n < 0) != (d < 0));
        for (int i = 0; i < 24; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= md) begin
                r = r - md;
                q = q | 1;
            end
        end
        return apply_sign(q, (n < 0) != (d < 0));
    endfunction

    function automatic t_pixel_result calibrate_pixel();
        t_pixel_result res;
        longint pix, dark, lo, hi, c0, c1, c2, c3, d, x, x2, x3, f, g, s2, y;
        longint unsigned sq;
        pix = longint'(i_pixel_value);
        dark = longint'(i_dark_value);
        lo = longint'(i_valid_low);
        hi = longint'(i_valid_high);
        c0 = longint'(i_coef_constant);
        c1 = longint'(i_coef_linear);
        c2 = longint'(i_coef_square);
        c3 = longint'(i_coef_cube);
        res.kind = KIND_NULL;
        res.radiance = '0;
        // Special kinds pass through; undefined kinds become null.
        if (i_pixel_kind != KIND_CAL) begin
            if (i_pixel_kind <= KIND_HRS) res.kind = i_pixel_kind;
            return res;
        end
        if (i_dark_special || (blemish_on && i_blemish_bad) || i_coef_special) return res;
        if (mask_on && (pix < lo || pix > hi)) return res;
        d = (pix - dark) * 256;
        if (d <= 0) return res;
        x = longint'(start_guess);
        for (int i = 0; i < STEPS; i++) begin
            x2 = fx_mul(x, x);
            x3 = fx_mul(x2, x);
            f = clamp48(fx_mul(c3, x3) + fx_mul(c2, x2));
            f = clamp48(f + fx_mul(c1, x));
            f = clamp48(f + clamp48(c0 - d));
            g = clamp48(clamp48(3 * fx_mul(c3, x2)) + clamp48(2 * fx_mul(c2, x)));
            g = clamp48(g + c1);
            // Skip the step on a flat slope.
            if (g != 0) x = clamp48(x - fx_div(f, g));
        end
        sq = longint'(sun_dist) * longint'(sun_dist);
        s2 = longint'((sq >> 24) + ((sq >> 23) & 1));
        y = fx_mul(x, s2);
        y = fx_mul(y, longint'(abs_coef) << 8);
        y = fx_div(y, longint'(exposure) << 8);
        res.kind = KIND_CAL;
        res.radiance = y[47:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            mask_on     <= 1'b0;
            blemish_on  <= 1'b0;
            start_guess <= '0;
            sun_dist    <= 32'd16777216;
            abs_coef    <= 32'd1048576;
            exposure    <= 32'd65536;
            o_failures  <= 0;
            o_checked   <= 0;
            calibrated_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MASK_EN:    mask_on     <= i_cfg_data[0];
                    CFG_BLEM_EN:    blemish_on  <= i_cfg_data[0];
                    CFG_INIT_GUESS: start_guess <= i_cfg_data;
                    CFG_SUN_DIST:   sun_dist    <= i_cfg_data[31:0];
                    CFG_ABS_COEF:   abs_coef    <= i_cfg_data[31:0];
                    CFG_EXPOSURE:   exposure    <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) calibrated_due.push_back(calibrate_pixel());
            if (i_out_valid && i_out_ready) begin
                o_checked <= o_checked + 1;
                if (calibrated_due.size() == 0) begin
                    if (o_failures < 10)
                        $display("%0t: unexpected result kind %0d radiance %0d",
                                 $realtime, i_out_kind, i_radiance);
                    o_failures <= o_failures + 1;
                end else begin
                    want = calibrated_due.pop_front();
                    if (want.kind !== i_out_kind || want.radiance !== i_radiance) begin
                        if (o_failures < 10)
                            $display("%0t: result %0d expected kind %0d radiance %0d, got %0d %0d",
                                     $realtime, o_checked, want.kind, want.radiance,
                                     i_out_kind, i_radiance);
                        o_failures <= o_failures + 1;
                    end
                end
            end
        end
    end

    assign o_pending = calibrated_due.size();

endmodule

@@ bench/tb_pixel_cubic_inverse_calibration_core.sv @@
// Testbench top for the calibration core: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module tb_pixel_cubic_inverse_calibration_core import pcic_pkg::*;;

    // Index above the register file; writes to it must be ignored.
    localparam logic [2:0] CFG_SPARE   = 3'd7;
    localparam int         PIPE_DEPTH  = 57 * 9 + 55;
    localparam int         HOLD_CYCLES = 1500;
    localparam logic [47:0] Q48_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q48_MIN    = 48'h8000_0000_0000;

    typedef struct {
        logic signed [31:0] pixel_value;
        logic [2:0]         pixel_kind;
        logic signed [31:0] dark_value;
        logic               dark_special;
        logic               blemish_bad;
        logic signed [47:0] coef_constant;
        logic signed [47:0] coef_linear;
        logic signed [47:0] coef_square;
        logic signed [47:0] coef_cube;
        logic signed [31:0] valid_low;
        logic signed [31:0] valid_high;
        logic               coef_special;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_pixel_value = '0;
    logic [2:0]         i_pixel_kind = '0;
    logic signed [31:0] i_dark_value = '0;
    logic               i_dark_special = 1'b0;
    logic               i_blemish_bad = 1'b0;
    logic signed [47:0] i_coef_constant = '0;
    logic signed [47:0] i_coef_linear = '0;
    logic signed [47:0] i_coef_square = '0;
    logic signed [47:0] i_coef_cube = '0;
    logic signed [31:0] i_valid_low = '0;
    logic signed [31:0] i_valid_high = '0;
    logic               i_coef_special = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_out_kind;
    logic signed [47:0] o_radiance;

    int failures, pending, checked;
    int pixels_sent = 0;
    bit calm = 1'b0;       // no idling on either side while set
    bit hold_req = 1'b0;   // ask the receiver for its long hold-off

    always #5 i_clk = ~i_clk;

    pixel_cubic_inverse_calibration_core dut (.*);

    pixel_cubic_inverse_calibration_core_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready),
        .i_pixel_value, .i_pixel_kind, .i_dark_value, .i_dark_special, .i_blemish_bad,
        .i_coef_constant, .i_coef_linear, .i_coef_square, .i_coef_cube,
        .i_valid_low, .i_valid_high, .i_coef_special,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_kind(o_out_kind),
        .i_radiance(o_radiance),
        .o_failures(failures), .o_pending(pending), .o_checked(checked)
    );

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Well-formed pixel: normal kind, clean dark and coefficient flags, positive signal, tame cubic.
    function automatic t_pixel clean_pixel();
        t_pixel p;
        p.pixel_kind    = KIND_CAL;
        p.dark_value    = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        p.pixel_value   = p.dark_value + $signed($urandom_range(1, 32'h0400_0000));
        p.dark_special  = 1'b0;
        p.blemish_bad   = 1'($urandom_range(0, 1));
        p.coef_special  = 1'b0;
        p.coef_constant = $signed(48'($urandom_range(0, 32'h0200_0000))) - 48'sh0100_0000;
        p.coef_linear   = $signed(48'($urandom_range(32'h0040_0000, 32'h0800_0000)));
        if ($urandom_range(0, 3) == 0) p.coef_linear = -p.coef_linear;
        p.coef_square   = $signed(48'($urandom_range(0, 32'h0002_0000))) - 48'sh0001_0000;
        p.coef_cube     = $signed(48'($urandom_range(0, 32'h0000_2000))) - 48'sh0000_1000;
        p.valid_low     = p.pixel_value - $signed($urandom_range(0, 32'h0100_0000));
        p.valid_high    = p.pixel_value + $signed($urandom_range(0, 32'h0100_0000));
        // Push some pixels just outside the bounds for the mask.
        if ($urandom_range(0, 9) == 0) p.valid_high = p.pixel_value - 1;
        if ($urandom_range(0, 9) == 0) p.valid_low = p.pixel_value + 1;
        return p;
    endfunction

    // Noise: every field over its whole range.
    function automatic t_pixel noise_pixel();
        t_pixel p;
        p.pixel_value   = $urandom;
        p.pixel_kind    = $urandom_range(0, 2) == 0 ? 3'($urandom_range(0, 7)) : KIND_CAL;
        p.dark_value    = $urandom;
        p.dark_special  = $urandom_range(0, 7) == 0;
        p.blemish_bad   = 1'($urandom_range(0, 1));
        p.coef_constant = rand48();
        p.coef_linear   = rand48();
        p.coef_square   = rand48();
        p.coef_cube     = rand48();
        p.valid_low     = $urandom;
        p.valid_high    = $urandom;
        p.coef_special  = $urandom_range(0, 7) == 0;
        return p;
    endfunction

    // Offer one pixel and hold it until the transaction completes.
    task automatic send_pixel(input t_pixel p);
        i_valid         <= 1'b1;
        i_pixel_value   <= p.pixel_value;
        i_pixel_kind    <= p.pixel_kind;
        i_dark_value    <= p.dark_value;
        i_dark_special  <= p.dark_special;
        i_blemish_bad   <= p.blemish_bad;
        i_coef_constant <= p.coef_constant;
        i_coef_linear   <= p.coef_linear;
        i_coef_square   <= p.coef_square;
        i_coef_cube     <= p.coef_cube;
        i_valid_low     <= p.valid_low;
        i_valid_high    <= p.valid_high;
        i_coef_special  <= p.coef_special;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        // Drop valid for a random gap now and then.
        if (!calm && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 23);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_pixel($urandom_range(0, 99) < 70 ? clean_pixel() : noise_pixel());
        end
    endtask

    // Drain the pipeline, then load a full register set.
    task automatic load_settings(input logic [47:0] vals[6]);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int r = 0; r < 6; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        // Let the squared sun distance settle.
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_directed();
        t_pixel base, p;
        base = clean_pixel();
        base.blemish_bad = 1'b0;
        send_pixel(base);
        // Every pass-through kind and both undefined kinds.
        for (int k = KIND_NULL; k <= 7; k++) begin
            p = base;
            p.pixel_kind = 3'(k);
            send_pixel(p);
        end
        p = base; p.dark_special = 1'b1; send_pixel(p);
        p = base; p.blemish_bad = 1'b1; send_pixel(p);
        p = base; p.coef_special = 1'b1; send_pixel(p);
        p = base; p.valid_high = p.pixel_value - 1; send_pixel(p);
        p = base; p.dark_value = p.pixel_value; send_pixel(p);
        p = base; p.dark_value = p.pixel_value + 1; send_pixel(p);
        // Largest positive dark-subtracted signal.
        p = base; p.pixel_value = 32'sh7FFF_FFFF; p.dark_value = 32'sh8000_0000;
        p.valid_low = 32'sh8000_0000; p.valid_high = 32'sh7FFF_FFFF;
        send_pixel(p);
        // Flat cubic: slope zero at every step.
        p = base; p.coef_linear = '0; p.coef_square = '0; p.coef_cube = '0; send_pixel(p);
        p = base; p.coef_constant = Q48_MAX; p.coef_linear = Q48_MAX;
        p.coef_square = Q48_MAX; p.coef_cube = Q48_MAX; send_pixel(p);
        p = base; p.coef_constant = Q48_MIN; p.coef_linear = Q48_MIN;
        p.coef_square = Q48_MIN; p.coef_cube = Q48_MIN; send_pixel(p);
        p = base; p.coef_linear = -p.coef_linear; send_pixel(p);
        p = base; p.coef_cube = 48'sh0100_0000; p.coef_linear = '0; send_pixel(p);
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= calm || $urandom_range(0, 99) >= 23;
        end
    end

    initial begin
        #(3_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [47:0] set_a[6], set_b[6], set_c[6], set_d[6], set_e[6];
        set_a = '{48'd1, 48'd1, 48'h0100_0000, 48'h0100_0000, 48'h0010_0000, 48'h0001_0000};
        set_b = '{48'd0, 48'd1, Q48_MAX, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 48'd1};
        set_c = '{48'd1, 48'd0, Q48_MIN, 48'd0, 48'd0, 48'hFFFF_FFFF};
        set_d = '{48'd1, 48'd1, 48'h0080_0000, 48'h0133_3333, 48'h0002_0000, 48'd0};
        set_e = '{48'd0, 48'd0, rand48(), 48'($urandom), 48'($urandom),
                  48'($urandom_range(1, 32'hFFFF_FFFF))};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: directed pixels, then random ones.
        send_directed();
        send_random(250);

        load_settings(set_a);
        send_directed();
        calm = 1'b1;
        send_random(270);
        calm = 1'b0;

        load_settings(set_b);
        // Hold the output while pixels keep coming, to fill the pipeline.
        hold_req = 1'b1;
        send_random(290);

        load_settings(set_c);
        send_random(290);

        load_settings(set_d);
        // A write to an unused index must change nothing.
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= rand48();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send_random(290);

        load_settings(set_e);
        send_random(270);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);

        $display("Sent %0d pixels over six register settings; %0d results checked.",
                 pixels_sent, checked);
        $display("Covered pass-through kinds, null checks, mask, zero exposure and stalls.");
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", failures);
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pcic_pkg.sv
rtl/pcic_qmul.sv
rtl/pcic_div_cell.sv
rtl/pcic_qdiv.sv
rtl/pcic_newton.sv
rtl/pixel_cubic_inverse_calibration_core.sv
bench/pixel_cubic_inverse_calibration_core_checker.sv
bench/tb_pixel_cubic_inverse_calibration_core.sv
